/* sv/a2c_pkg.sv */
// Shared types and constants for the alignment to CIGAR encoder.
`default_nettype none
package a2c_pkg;

  localparam int LEN_BITS = 28;
  localparam int QDEPTH   = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_COLUMN = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_M = 2'd0,
    KIND_I = 2'd1,
    KIND_D = 2'd2,
    KIND_S = 2'd3
  } kind_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] run_length;
    kind_t               run_kind;
    logic                last;
    logic                gap_pair_error;
  } res_t;

  // Up to two results handed to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage
`default_nettype wire

/* sv/a2c_if.sv */
// Valid/ready channel interfaces for alignment items and CIGAR results.
`default_nettype none
interface a2c_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  query_byte;
  logic [7:0]  subject_byte;
  logic [27:0] query_offset;
  logic [27:0] query_end;
  logic [27:0] query_length;

  modport source (
    output valid, op, query_byte, subject_byte, query_offset, query_end, query_length,
    input  ready
  );
  modport sink (
    input  valid, op, query_byte, subject_byte, query_offset, query_end, query_length,
    output ready
  );
endinterface

interface a2c_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] run_length;
  logic [1:0]  run_kind;
  logic        last;
  logic        gap_pair_error;

  modport source (
    output valid, run_length, run_kind, last, gap_pair_error,
    input  ready
  );
  modport sink (
    input  valid, run_length, run_kind, last, gap_pair_error,
    output ready
  );
endinterface
`default_nettype wire

/* sv/alignment_to_cigar_encoder.sv */
// Top level of the alignment to CIGAR run-length encoder.
//
// Usage:
//   ingress carries one request per alignment step: op start (leading soft
//   clip from query_offset), op column (query_byte, subject_byte) or op
//   finish (flush the open run, trailing clip query_length - query_end).
//   egress carries CIGAR operations as run_length and run_kind
//   (M, I, D, S); last marks the final operation of an alignment and
//   gap_pair_error carries the sticky double-gap flag on that operation.
//   cfg_write/cfg_data set the gap byte (45 after reset); write only idle.
// Path: a request is registered in the input register, then its results enter
//   a four-entry queue, and egress delivers them from the queue head.
// Throughput: one request per cycle while the queue has room; columns yield
//   at most one result, a finish may yield two, which the queue absorbs.
// Reset: rst clears the open run, the error flag and the queue, and
//   restores the gap byte.
// Stall: with egress held, the queue fills; ingress ready drops once
//   fewer than two free slots remain and the registered request holds.
`default_nettype none
module alignment_to_cigar_encoder #(
  parameter int COUNT_BITS = 28
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  a2c_in_if.sink          ingress,
  a2c_out_if.source       egress
);

  // results handed from the step logic to the queue
  a2c_pkg::push_t push;
  logic           room;

  // step logic: input register, run state, result forming
  a2c_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .ingress   (ingress),
    .push      (push),
    .room      (room)
  );

  // result queue: decouple the two-result finish from the receiver
  a2c_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .egress (egress)
  );

endmodule
`default_nettype wire

/* sv/a2c_core.sv */
// Input register, run tracking state and result formation.
`default_nettype none
module a2c_core #(
  parameter int COUNT_BITS = 28
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [7:0]    cfg_data,
  a2c_in_if.sink             ingress,
  output a2c_pkg::push_t     push,
  input  wire logic          room
);

  localparam int LB = a2c_pkg::LEN_BITS;
  localparam int CW = (COUNT_BITS < LB) ? COUNT_BITS : LB;
  localparam logic [LB-1:0] CNT_MAX = LB'((64'd1 << CW) - 64'd1);

  logic          in_valid;
  logic [1:0]    in_op;
  logic [7:0]    in_qbyte;
  logic [7:0]    in_sbyte;
  logic [LB-1:0] in_qoff;
  logic [LB-1:0] in_qend;
  logic [LB-1:0] in_qsize;

  logic [7:0]          gap_code;
  a2c_pkg::kind_t      open_kind, open_kind_next;
  logic [CW-1:0]       open_count, open_count_next;
  logic                run_open, run_open_next;
  logic                error_seen, error_seen_next;

  logic                fire;
  logic                q_gap, s_gap, tail;
  a2c_pkg::kind_t      col_kind;
  a2c_pkg::res_t       run_res, tail_res, empty_res;
  logic [LB-1:0]       tail_len;

  function automatic logic [LB-1:0] sat(input logic [LB-1:0] v);
    sat = (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  assign fire          = in_valid && room;
  assign ingress.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ingress.ready) begin
      in_valid <= ingress.valid;
    end
    if (ingress.ready && ingress.valid) begin
      in_op    <= ingress.op;
      in_qbyte <= ingress.query_byte;
      in_sbyte <= ingress.subject_byte;
      in_qoff  <= ingress.query_offset;
      in_qend  <= ingress.query_end;
      in_qsize <= ingress.query_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_code   <= 8'd45;
      open_kind  <= a2c_pkg::KIND_M;
      open_count <= '0;
      run_open   <= 1'b0;
      error_seen <= 1'b0;
    end else begin
      if (cfg_write) begin
        gap_code <= cfg_data;
      end
      open_kind  <= open_kind_next;
      open_count <= open_count_next;
      run_open   <= run_open_next;
      error_seen <= error_seen_next;
    end
  end

  assign q_gap    = (in_qbyte == gap_code);
  assign s_gap    = (in_sbyte == gap_code);
  assign col_kind = q_gap ? a2c_pkg::KIND_D : (s_gap ? a2c_pkg::KIND_I : a2c_pkg::KIND_M);
  assign tail     = (in_qend < in_qsize);
  assign tail_len = in_qsize - in_qend;

  always_comb begin
    run_res.run_length     = LB'(open_count);
    run_res.run_kind       = open_kind;
    run_res.last           = 1'b0;
    run_res.gap_pair_error = 1'b0;
    tail_res.run_length     = sat(tail_len);
    tail_res.run_kind       = a2c_pkg::KIND_S;
    tail_res.last           = 1'b1;
    tail_res.gap_pair_error = error_seen;
    empty_res.run_length     = '0;
    empty_res.run_kind       = a2c_pkg::KIND_M;
    empty_res.last           = 1'b1;
    empty_res.gap_pair_error = error_seen;
  end

  always_comb begin
    open_kind_next  = open_kind;
    open_count_next = open_count;
    run_open_next   = run_open;
    error_seen_next = error_seen;
    push            = '0;
    if (fire) begin
      unique case (in_op)
        a2c_pkg::OP_START: begin
          error_seen_next = 1'b0;
          run_open_next   = 1'b0;
          open_count_next = '0;
          open_kind_next  = a2c_pkg::KIND_M;
          if (in_qoff != '0) begin
            push.count                = 2'd1;
            push.first.run_length     = sat(in_qoff);
            push.first.run_kind       = a2c_pkg::KIND_S;
            push.first.last           = 1'b0;
            push.first.gap_pair_error = 1'b0;
          end
        end
        a2c_pkg::OP_COLUMN: begin
          if (q_gap && s_gap) begin
            // drop the column, remember the fault
            error_seen_next = 1'b1;
          end else if (run_open && open_kind == col_kind) begin
            if (open_count != '1) begin
              open_count_next = open_count + 1'b1;
            end
          end else begin
            if (run_open) begin
              push.count = 2'd1;
              push.first = run_res;
            end
            run_open_next   = 1'b1;
            open_kind_next  = col_kind;
            open_count_next = CW'(1);
          end
        end
        a2c_pkg::OP_FINISH: begin
          run_open_next   = 1'b0;
          open_count_next = '0;
          open_kind_next  = a2c_pkg::KIND_M;
          if (run_open) begin
            push.first                = run_res;
            push.first.last           = !tail;
            push.first.gap_pair_error = !tail && error_seen;
            push.second               = tail_res;
            push.count                = tail ? 2'd2 : 2'd1;
          end else begin
            push.first = tail ? tail_res : empty_res;
            push.count = 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_col_no_double: assert property (@(posedge clk) disable iff (rst)
    (fire && in_op == a2c_pkg::OP_COLUMN) |-> (push.count != 2'd2))
    else $error("column produced two results");

  a_finish_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && in_op == a2c_pkg::OP_FINISH) |=> !run_open)
    else $error("run still open after finish");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_op == a2c_pkg::OP_START) |=> (!error_seen && !run_open))
    else $error("start left state behind");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_open |-> (open_count != '0))
    else $error("open run with zero length");

endmodule
`default_nettype wire

/* sv/a2c_outq.sv */
// Small result queue: takes up to two results a cycle, delivers one while egress is ready.
`default_nettype none
module a2c_outq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire a2c_pkg::push_t            push,
  output logic                           room,
  a2c_out_if.source                      egress
);

  localparam int PW = a2c_pkg::QPTR_BITS;
  localparam int CN = a2c_pkg::QCNT_BITS;

  a2c_pkg::res_t  slots [a2c_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CN-1:0]  count, count_next;
  logic           pop;
  a2c_pkg::res_t  head;

  assign pop  = egress.valid && egress.ready;
  assign room = (count <= CN'(a2c_pkg::QDEPTH - 2));
  assign head = slots[rd_ptr];

  assign egress.valid          = (count != '0);
  assign egress.run_length     = head.run_length;
  assign egress.run_kind       = head.run_kind;
  assign egress.last           = head.last;
  assign egress.gap_pair_error = head.gap_pair_error;

  assign count_next = count + CN'(push.count) - CN'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + PW'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CN'(a2c_pkg::QDEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == CN'($past(count) + CN'($past(push.count)) - CN'($past(pop)))))
    else $error("queue level mismatch");

endmodule
`default_nettype wire
